/* rtl/core/dcpo_pkg.sv */
// ---------------------------------------------------------------------------
// dcpo_pkg - shared types and constants of the drive command parser
// frame layout, direction codes, command digits and drive state bundle
// ---------------------------------------------------------------------------
`default_nettype none

package dcpo_pkg;

    localparam int FRAME_LEN  = 5;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = 3;
    localparam int BUF_DEPTH  = FRAME_LEN - 1;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);
    localparam int TLM_BYTES  = 6;
    localparam int BURST_BITS = 3;

    localparam logic [7:0] HDR_CMD = 8'h50;   // 'P'
    localparam logic [7:0] HDR_TLM = 8'h45;   // 'E'

    // command digits
    localparam logic [7:0] CMD_REV_LEFT   = 8'h31;
    localparam logic [7:0] CMD_REVERSE    = 8'h32;
    localparam logic [7:0] CMD_REV_RIGHT  = 8'h33;
    localparam logic [7:0] CMD_SPIN_LEFT  = 8'h34;
    localparam logic [7:0] CMD_STOP       = 8'h35;
    localparam logic [7:0] CMD_SPIN_RIGHT = 8'h36;
    localparam logic [7:0] CMD_FWD_RIGHT  = 8'h37;
    localparam logic [7:0] CMD_FORWARD    = 8'h38;
    localparam logic [7:0] CMD_FWD_LEFT   = 8'h39;

    // bridge patterns
    localparam logic [3:0] PAT_REV_LEFT   = 4'h8;
    localparam logic [3:0] PAT_REVERSE    = 4'h9;
    localparam logic [3:0] PAT_REV_RIGHT  = 4'h1;
    localparam logic [3:0] PAT_SPIN_LEFT  = 4'hA;
    localparam logic [3:0] PAT_STOP       = 4'h0;
    localparam logic [3:0] PAT_SPIN_RIGHT = 4'h5;
    localparam logic [3:0] PAT_FWD_RIGHT  = 4'h2;
    localparam logic [3:0] PAT_FORWARD    = 4'h6;
    localparam logic [3:0] PAT_FWD_LEFT   = 4'h4;

    localparam logic [7:0] DUTY_RESET = 8'hFF;

    typedef enum logic [1:0] {
        ACT_RX          = 2'd0,
        ACT_LEFT_PULSE  = 2'd1,
        ACT_RIGHT_PULSE = 2'd2,
        ACT_TICK        = 2'd3
    } action_t;

    // two's complement wheel direction
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd3
    } dir_t;

    typedef struct packed {
        logic [3:0] pattern;
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        dir_t       left_dir;
        dir_t       right_dir;
    } drive_state_t;

    typedef struct packed {
        logic       known;
        logic [3:0] pattern;
        dir_t       left_dir;
        dir_t       right_dir;
    } digit_dec_t;

    function automatic digit_dec_t decode_digit(input logic [7:0] digit);
        digit_dec_t d;
        d = '{known: 1'b1, pattern: PAT_STOP, left_dir: DIR_IDLE, right_dir: DIR_IDLE};
        unique case (digit)
            CMD_REV_LEFT: begin
                d.pattern = PAT_REV_LEFT;   d.left_dir = DIR_BACK; d.right_dir = DIR_IDLE;
            end
            CMD_REVERSE: begin
                d.pattern = PAT_REVERSE;    d.left_dir = DIR_BACK; d.right_dir = DIR_BACK;
            end
            CMD_REV_RIGHT: begin
                d.pattern = PAT_REV_RIGHT;  d.left_dir = DIR_IDLE; d.right_dir = DIR_BACK;
            end
            CMD_SPIN_LEFT: begin
                d.pattern = PAT_SPIN_LEFT;  d.left_dir = DIR_BACK; d.right_dir = DIR_FWD;
            end
            CMD_STOP: begin
                d.pattern = PAT_STOP;       d.left_dir = DIR_IDLE; d.right_dir = DIR_IDLE;
            end
            CMD_SPIN_RIGHT: begin
                d.pattern = PAT_SPIN_RIGHT; d.left_dir = DIR_FWD;  d.right_dir = DIR_BACK;
            end
            CMD_FWD_RIGHT: begin
                d.pattern = PAT_FWD_RIGHT;  d.left_dir = DIR_IDLE; d.right_dir = DIR_FWD;
            end
            CMD_FORWARD: begin
                d.pattern = PAT_FORWARD;    d.left_dir = DIR_FWD;  d.right_dir = DIR_FWD;
            end
            CMD_FWD_LEFT: begin
                d.pattern = PAT_FWD_LEFT;   d.left_dir = DIR_FWD;  d.right_dir = DIR_IDLE;
            end
            default: begin
                d.known = 1'b0;
            end
        endcase
        return d;
    endfunction

    function automatic logic [COUNT_BITS-1:0] step_count(input logic [COUNT_BITS-1:0] cnt,
                                                          input dir_t dir);
        logic [COUNT_BITS-1:0] res;
        res = cnt;
        if (dir == DIR_FWD) begin
            res = cnt + COUNT_BITS'(1);
        end else if (dir == DIR_BACK) begin
            res = cnt - COUNT_BITS'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dcpo_frame_parser.sv */
// ---------------------------------------------------------------------------
// dcpo_frame_parser - five-byte drive command framing
// holds the frame bytes, duties, bridge pattern and wheel directions
// ---------------------------------------------------------------------------
`default_nettype none

module dcpo_frame_parser
    import dcpo_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         take,
    input  wire action_t      action,
    input  wire logic [7:0]   rx_byte,
    output drive_state_t      drive_next,
    output logic              cmd_taken
);

    logic [7:0]          frame_buffer [BUF_DEPTH];
    logic [IDX_BITS-1:0] byte_index_reg, byte_index_next;
    drive_state_t        drive_reg;
    logic                store_byte;
    logic [7:0]          sum;
    digit_dec_t          dec;
    logic                rx_take;

    assign rx_take = take && (action == ACT_RX);
    assign sum     = frame_buffer[2] + frame_buffer[3];
    assign dec     = decode_digit(frame_buffer[1]);

    always_comb begin
        byte_index_next = byte_index_reg;
        drive_next      = drive_reg;
        cmd_taken       = 1'b0;
        store_byte      = 1'b0;
        if (rx_take) begin
            if (byte_index_reg == '0) begin
                store_byte      = 1'b1;
                byte_index_next = (rx_byte == HDR_CMD) ? IDX_BITS'(1) : '0;
            end else if (byte_index_reg == IDX_BITS'(FRAME_LEN - 1)) begin
                // checksum byte closes the frame either way
                byte_index_next = '0;
                if (rx_byte == sum) begin
                    cmd_taken             = 1'b1;
                    drive_next.left_duty  = frame_buffer[2];
                    drive_next.right_duty = frame_buffer[3];
                    if (dec.known) begin
                        drive_next.pattern   = dec.pattern;
                        drive_next.left_dir  = dec.left_dir;
                        drive_next.right_dir = dec.right_dir;
                    end
                end
            end else begin
                store_byte      = 1'b1;
                byte_index_next = byte_index_reg + IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg       <= '0;
            drive_reg.pattern    <= PAT_STOP;
            drive_reg.left_duty  <= DUTY_RESET;
            drive_reg.right_duty <= DUTY_RESET;
            drive_reg.left_dir   <= DIR_IDLE;
            drive_reg.right_dir  <= DIR_IDLE;
        end else begin
            byte_index_reg <= byte_index_next;
            drive_reg      <= drive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_byte) begin
            frame_buffer[byte_index_reg[BUF_AW-1:0]] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dcpo_odometer.sv */
// ---------------------------------------------------------------------------
// dcpo_odometer - wheel encoder counters
// steps each wheel count by its direction on a pulse, wrapping
// ---------------------------------------------------------------------------
`default_nettype none

module dcpo_odometer
    import dcpo_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  take,
    input  wire action_t               action,
    input  wire dir_t                  left_dir,
    input  wire dir_t                  right_dir,
    output logic [COUNT_BITS-1:0]      left_count,
    output logic [COUNT_BITS-1:0]      right_count
);

    logic [COUNT_BITS-1:0] left_count_reg, left_count_next;
    logic [COUNT_BITS-1:0] right_count_reg, right_count_next;

    always_comb begin
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        if (take && action == ACT_LEFT_PULSE) begin
            left_count_next = step_count(left_count_reg, left_dir);
        end
        if (take && action == ACT_RIGHT_PULSE) begin
            right_count_next = step_count(right_count_reg, right_dir);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
        end else begin
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
        end
    end

    assign left_count  = left_count_reg;
    assign right_count = right_count_reg;

endmodule

`default_nettype wire

/* rtl/core/dcpo_result_stage.sv */
// ---------------------------------------------------------------------------
// dcpo_result_stage - result register and telemetry burst sequencer
// one result per request, six beats per telemetry tick
// ---------------------------------------------------------------------------
`default_nettype none

module dcpo_result_stage
    import dcpo_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  take,
    input  wire action_t               action,
    input  wire drive_state_t          drive_next,
    input  wire logic                  cmd_taken,
    input  wire logic [COUNT_BITS-1:0] left_count,
    input  wire logic [COUNT_BITS-1:0] right_count,
    output logic                       can_take,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,
    output logic                       m_tlast,
    output logic [0:0]                 m_tuser
);

    logic                  out_valid_reg;
    logic [BURST_BITS-1:0] burst_cnt_reg;
    logic                  tx_valid_reg;
    logic [7:0]            tx_byte_reg;
    logic                  tx_last_reg;
    logic [3:0]            pattern_reg;
    logic [7:0]            left_duty_reg;
    logic [7:0]            right_duty_reg;
    logic                  taken_reg;
    logic [7:0]            snap_reg [TLM_BYTES-1];

    logic [31:0] left_ext, right_ext;
    logic [7:0]  tlm [TLM_BYTES-1];
    logic        out_pop;
    logic        burst_step;
    logic        is_tick;

    assign left_ext  = 32'(left_count);
    assign right_ext = 32'(right_count);
    assign tlm[0] = right_ext[15:8];
    assign tlm[1] = right_ext[7:0];
    assign tlm[2] = left_ext[15:8];
    assign tlm[3] = left_ext[7:0];
    assign tlm[4] = tlm[0] + tlm[1] + tlm[2] + tlm[3];

    assign is_tick    = (action == ACT_TICK);
    assign out_pop    = out_valid_reg && m_tready;
    assign burst_step = out_pop && (burst_cnt_reg != '0);
    assign can_take   = (burst_cnt_reg == '0) && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            burst_cnt_reg <= '0;
        end else if (take) begin
            out_valid_reg <= 1'b1;
            burst_cnt_reg <= is_tick ? BURST_BITS'(TLM_BYTES - 1) : '0;
        end else if (burst_step) begin
            burst_cnt_reg <= burst_cnt_reg - BURST_BITS'(1);
        end else if (out_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            tx_valid_reg   <= is_tick;
            tx_byte_reg    <= is_tick ? HDR_TLM : 8'h00;
            tx_last_reg    <= !is_tick;
            pattern_reg    <= drive_next.pattern;
            left_duty_reg  <= drive_next.left_duty;
            right_duty_reg <= drive_next.right_duty;
            taken_reg      <= cmd_taken;
            for (int i = 0; i < TLM_BYTES - 1; i++) begin
                snap_reg[i] <= tlm[i];
            end
        end else if (burst_step) begin
            tx_byte_reg <= snap_reg[0];
            tx_last_reg <= (burst_cnt_reg == BURST_BITS'(1));
            for (int i = 0; i < TLM_BYTES - 2; i++) begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tlast    = tx_last_reg;
    assign m_tuser[0] = tx_valid_reg;
    assign m_tdata    = {3'b000, taken_reg, right_duty_reg, left_duty_reg,
                         pattern_reg, tx_byte_reg};

endmodule

`default_nettype wire

/* rtl/core/drive_command_parser_with_odometry.sv */
// ---------------------------------------------------------------------------
// drive_command_parser_with_odometry - drive command framing and odometry
//
// requests enter on the s_ stream: tuser carries the kind of request
// (received byte, left encoder pulse, right encoder pulse, telemetry tick)
// and tdata the received byte. command frames are 'P', direction digit,
// left duty, right duty, checksum (sum of the duties, modulo 256); a good
// frame loads the duties and, for a known digit, pattern and directions.
// results leave on the m_ stream. every request gives one result, except a
// telemetry tick which gives a six-beat burst: 'E', right count high/low,
// left count high/low, byte sum; tlast marks the final beat of a request.
// a result is registered in the cycle after its request. a new request is
// taken every cycle while the result register is free or being emptied;
// a tick holds s_tready low while the first five beats of its burst are
// out, so the next request goes in with the final beat at the earliest.
// if the receiver stalls, the result register holds and s_tready drops.
// reset (aresetn low, synchronous) clears framing, counts, pattern and
// directions, sets both duties to full scale and empties the output.
// ---------------------------------------------------------------------------
`default_nettype none

module drive_command_parser_with_odometry
    import dcpo_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] tx_byte, [11:8] drive_pattern,
                                        // [19:12] left_duty, [27:20] right_duty,
                                        // [28] command_taken, [31:29] zero
    output logic             m_tlast,   // tx_last
    output logic [0:0]       m_tuser    // [0] tx_valid
);

    logic                  take;
    logic                  can_take;
    action_t               action;
    drive_state_t          drive_next;
    logic                  cmd_taken;
    logic [COUNT_BITS-1:0] left_count;
    logic [COUNT_BITS-1:0] right_count;

    // request handshake
    assign s_tready = can_take;
    assign take     = s_tvalid && can_take;
    assign action   = action_t'(s_tuser);

    // framing, duties, pattern and wheel directions
    dcpo_frame_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .action     (action),
        .rx_byte    (s_tdata),
        .drive_next (drive_next),
        .cmd_taken  (cmd_taken)
    );

    // wheel counts; a pulse never changes the directions, so the
    // post-request directions equal the stored ones here
    dcpo_odometer u_odometer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .action      (action),
        .left_dir    (drive_next.left_dir),
        .right_dir   (drive_next.right_dir),
        .left_count  (left_count),
        .right_count (right_count)
    );

    // result register and telemetry burst
    dcpo_result_stage u_result (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .action      (action),
        .drive_next  (drive_next),
        .cmd_taken   (cmd_taken),
        .left_count  (left_count),
        .right_count (right_count),
        .can_take    (can_take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

/* rtl/core/dcpo_checker.sv */
// ---------------------------------------------------------------------------
// dcpo_checker - port-level checks of the drive command parser
// result framing, burst flow control and result hold under stall
// ---------------------------------------------------------------------------
`default_nettype none

module dcpo_checker
    import dcpo_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic [0:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // only telemetry results span more than one beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("non-telemetry result without tlast");

    // no request is taken inside a telemetry burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && !m_tlast |-> !s_tready)
        else $error("request taken during telemetry burst");

    // a taken command is never flagged on telemetry beats
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28] |-> !m_tuser[0])
        else $error("command flag on telemetry beat");

    // a telemetry burst opens with the header byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_TICK) |=>
            m_tvalid && m_tuser[0] && (m_tdata[7:0] == HDR_TLM) && !m_tlast)
        else $error("telemetry burst without header");

endmodule

bind drive_command_parser_with_odometry dcpo_checker u_dcpo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
